[hdl/clr_pkg.sv]
package clr_pkg;

    localparam int SAMPLE_BITS = 16;
    localparam int FRAC_BITS   = 16;
    localparam int IDX_W       = 11;
    localparam int LEN_W       = 12;
    localparam int RATIO_W     = 20;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 20;

    // position: signed offset times ratio, plus centre
    localparam int POS_W  = LEN_W + RATIO_W + 1;
    localparam int PROD_W = SAMPLE_BITS + FRAC_BITS + 2;

    localparam logic signed [POS_W-1:0] ONE_POS = POS_W'(1) << FRAC_BITS;
    localparam logic signed [PROD_W-1:0] ROUND_HALF = PROD_W'(1) << (FRAC_BITS - 1);

    localparam logic REQ_WRITE = 1'b0;
    localparam logic REQ_READ  = 1'b1;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SRC_LENGTH  = 2'd0,
        CFG_DEST_LENGTH = 2'd1,
        CFG_RATIO       = 2'd2
    } t_cfg_reg;

    typedef struct packed {
        logic [IDX_W-1:0]          dhalf;
        logic [RATIO_W-1:0]        ratio;
        logic signed [POS_W-1:0]   half_pos;
        logic signed [POS_W-1:0]   hi_pos;
    } t_pos_cfg;

    typedef struct packed {
        logic                          is_req;
        logic                          in_range;
        logic [LEN_W-1:0]              lo;
        logic [FRAC_BITS-1:0]          frac;
        logic [IDX_W-1:0]              wr_index;
        logic signed [SAMPLE_BITS-1:0] wr_value;
        logic [IDX_W-1:0]              dest_index;
    } t_pos_item;

endpackage

[hdl/clr_pos_pipe.sv]
module clr_pos_pipe (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  clr_pkg::t_pos_cfg                      i_cfg,
    input  logic                                   i_valid,
    output logic                                   o_ready,
    input  logic                                   i_req_type,
    input  logic [clr_pkg::IDX_W-1:0]              i_sample_index,
    input  logic signed [clr_pkg::SAMPLE_BITS-1:0] i_sample_value,
    input  logic [clr_pkg::IDX_W-1:0]              i_dest_index,
    output logic                                   o_valid,
    input  logic                                   i_next_ready,
    output clr_pkg::t_pos_item                     o_item
);
    import clr_pkg::*;

    logic                          w_en1, w_en2, w_en3;

    logic                          r_v1;
    logic                          r_req1;
    logic [IDX_W-1:0]              r_widx1;
    logic signed [SAMPLE_BITS-1:0] r_wval1;
    logic [IDX_W-1:0]              r_didx1;
    logic signed [LEN_W-1:0]       r_d1;

    logic                          r_v2;
    logic                          r_req2;
    logic [IDX_W-1:0]              r_widx2;
    logic signed [SAMPLE_BITS-1:0] r_wval2;
    logic [IDX_W-1:0]              r_didx2;
    logic signed [POS_W-1:0]       r_prod2;

    logic                          r_v3;
    t_pos_item                     r_item3;

    logic signed [LEN_W-1:0]       n_d;
    logic signed [RATIO_W:0]       w_ratio_s;
    logic signed [POS_W-1:0]       w_pos;
    t_pos_item                     n_item;

    // each stage moves when it is empty or the next one moves
    assign w_en3   = !r_v3 || i_next_ready;
    assign w_en2   = !r_v2 || w_en3;
    assign w_en1   = !r_v1 || w_en2;
    assign o_ready = w_en1;

    assign n_d       = $signed({1'b0, i_dest_index}) - $signed({1'b0, i_cfg.dhalf});
    assign w_ratio_s = $signed({1'b0, i_cfg.ratio});
    assign w_pos     = r_prod2 + i_cfg.half_pos;

    always_comb begin
        n_item            = '0;
        n_item.is_req     = r_req2;
        // strictly inside the open interval (1, 2*half-1)
        n_item.in_range   = (w_pos > ONE_POS) && (w_pos < i_cfg.hi_pos);
        n_item.lo         = w_pos[FRAC_BITS +: LEN_W];
        n_item.frac       = w_pos[FRAC_BITS-1:0];
        n_item.wr_index   = r_widx2;
        n_item.wr_value   = r_wval2;
        n_item.dest_index = r_didx2;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            if (w_en1) begin
                r_v1 <= i_valid;
            end
            if (w_en2) begin
                r_v2 <= r_v1;
            end
            if (w_en3) begin
                r_v3 <= r_v2;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en1) begin
            r_req1  <= i_req_type;
            r_widx1 <= i_sample_index;
            r_wval1 <= i_sample_value;
            r_didx1 <= i_dest_index;
            r_d1    <= n_d;
        end
        if (w_en2) begin
            r_req2  <= r_req1;
            r_widx2 <= r_widx1;
            r_wval2 <= r_wval1;
            r_didx2 <= r_didx1;
            r_prod2 <= r_d1 * w_ratio_s;
        end
        if (w_en3) begin
            r_item3 <= n_item;
        end
    end

    assign o_valid = r_v3;
    assign o_item  = r_item3;

endmodule

[hdl/centered_linear_resampler_top.sv]
// centered linear resampler
// input channel (i_valid / o_stall) carries two kinds of item: a write stores
// i_sample_value at i_sample_index in the source frame memory, a request asks
// for destination sample i_dest_index. only requests give a result on the
// output channel (o_valid / i_stall): interpolated sample, its index and an
// in-range flag; out-of-range positions give zero with o_in_range low.
// configuration (source length, destination length, q4.16 ratio) is written
// through i_cfg_we / i_cfg_index / i_cfg_data; the user must write it only
// while the block is idle, the block itself does not enforce this.
// six register stages: offset, ratio multiply, position add and range check,
// frame memory access, difference multiply, rounding and output register.
// writes reach the memory in the frame memory access stage, in item order.
// one item per cycle sustained while the receiver does not stall, set by the
// single ratio multiplier and the two-read-port frame memory, each used once
// per item. when the receiver stalls, bubbles are squeezed out and o_stall
// rises only once every stage holds an item. reset empties the pipeline and
// loads the register defaults; the frame memory is not cleared.
module centered_linear_resampler_top #(
    parameter int MAX_FRAME_LEN = 2048
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_cfg_we,
    input  logic [clr_pkg::CFG_IDX_W-1:0]          i_cfg_index,
    input  logic [clr_pkg::CFG_DATA_W-1:0]         i_cfg_data,
    input  logic                                   i_valid,
    output logic                                   o_stall,
    input  logic                                   i_req_type,
    input  logic [clr_pkg::IDX_W-1:0]              i_sample_index,
    input  logic signed [clr_pkg::SAMPLE_BITS-1:0] i_sample_value,
    input  logic [clr_pkg::IDX_W-1:0]              i_dest_index,
    output logic                                   o_valid,
    input  logic                                   i_stall,
    output logic signed [clr_pkg::SAMPLE_BITS-1:0] o_out_sample,
    output logic [clr_pkg::IDX_W-1:0]              o_out_index,
    output logic                                   o_in_range
);
    import clr_pkg::*;

    localparam int AW = $clog2(MAX_FRAME_LEN);
    localparam int SB = SAMPLE_BITS;

    logic [LEN_W-1:0]        r_src_length;
    logic [LEN_W-1:0]        r_dest_length;
    logic [RATIO_W-1:0]      r_ratio;

    logic [LEN_W-1:0]        w_len;
    logic [IDX_W-1:0]        w_half;
    logic signed [LEN_W:0]   w_hi_units;
    t_pos_cfg                w_pos_cfg;

    logic                    w_ready;
    logic                    w_pos_valid;
    t_pos_item               w_pos_item;

    logic                    w_en4, w_en5, w_en6;
    logic                    w_wr;
    logic [AW+IDX_W-1:0]     w_widx_ext;
    logic [LEN_W-1:0]        w_lo1;
    logic [AW+LEN_W-1:0]     w_a0_ext, w_a1_ext;
    logic [AW-1:0]           w_waddr, w_a0, w_a1;

    logic signed [SB-1:0]    r_mem [MAX_FRAME_LEN];

    logic                    r_v4;
    logic signed [SB-1:0]    r_s0_4, r_s1_4;
    logic                    r_ok4;
    logic [FRAC_BITS-1:0]    r_frac4;
    logic [IDX_W-1:0]        r_didx4;

    logic                    r_v5;
    logic signed [PROD_W-1:0] r_prod5;
    logic signed [SB-1:0]    r_s0_5;
    logic                    r_ok5;
    logic [IDX_W-1:0]        r_didx5;

    logic                    r_v6;
    logic signed [SB-1:0]    r_out6;
    logic                    r_ok6;
    logic [IDX_W-1:0]        r_didx6;

    logic signed [SB:0]      w_diff;
    logic signed [PROD_W-1:0] w_rnd;
    logic signed [SB+1:0]    w_res;
    logic signed [SB-1:0]    n_out;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_src_length  <= LEN_W'(2048);
            r_dest_length <= LEN_W'(2048);
            r_ratio       <= RATIO_W'(52429);
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_SRC_LENGTH:  r_src_length  <= i_cfg_data[LEN_W-1:0];
                CFG_DEST_LENGTH: r_dest_length <= i_cfg_data[LEN_W-1:0];
                CFG_RATIO:       r_ratio       <= i_cfg_data[RATIO_W-1:0];
                default: ;
            endcase
        end
    end

    assign w_len      = (32'(r_src_length) > MAX_FRAME_LEN) ? LEN_W'(MAX_FRAME_LEN)
                                                            : r_src_length;
    assign w_half     = w_len[LEN_W-1:1];
    assign w_hi_units = $signed({1'b0, w_half, 1'b0}) - $signed((LEN_W+1)'(1));

    always_comb begin
        w_pos_cfg          = '0;
        w_pos_cfg.dhalf    = r_dest_length[LEN_W-1:1];
        w_pos_cfg.ratio    = r_ratio;
        w_pos_cfg.half_pos = $signed({{(POS_W-IDX_W-FRAC_BITS){1'b0}}, w_half,
                                      {FRAC_BITS{1'b0}}});
        w_pos_cfg.hi_pos   = $signed({{(POS_W-LEN_W-1-FRAC_BITS){w_hi_units[LEN_W]}},
                                      w_hi_units, {FRAC_BITS{1'b0}}});
    end

    clr_pos_pipe u_pos (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg          (w_pos_cfg),
        .i_valid        (i_valid),
        .o_ready        (w_ready),
        .i_req_type     (i_req_type),
        .i_sample_index (i_sample_index),
        .i_sample_value (i_sample_value),
        .i_dest_index   (i_dest_index),
        .o_valid        (w_pos_valid),
        .i_next_ready   (w_en4),
        .o_item         (w_pos_item)
    );

    assign o_stall = !w_ready;

    assign w_en6 = !r_v6 || !i_stall;
    assign w_en5 = !r_v5 || w_en6;
    assign w_en4 = !r_v4 || w_en5;

    // memory stage: writes are applied here so they stay in order with reads
    assign w_widx_ext = {{AW{1'b0}}, w_pos_item.wr_index};
    assign w_waddr    = w_widx_ext[AW-1:0];
    assign w_wr       = w_en4 && w_pos_valid && (w_pos_item.is_req == REQ_WRITE)
                        && (32'(w_pos_item.wr_index) < MAX_FRAME_LEN);
    assign w_lo1      = w_pos_item.lo + LEN_W'(1);
    assign w_a0_ext   = {{AW{1'b0}}, w_pos_item.lo};
    assign w_a1_ext   = {{AW{1'b0}}, w_lo1};
    assign w_a0       = w_a0_ext[AW-1:0];
    assign w_a1       = w_a1_ext[AW-1:0];

    always_ff @(posedge i_clk) begin
        if (w_wr) begin
            r_mem[w_waddr] <= w_pos_item.wr_value;
        end
        if (w_en4) begin
            r_s0_4 <= r_mem[w_a0];
            r_s1_4 <= r_mem[w_a1];
        end
    end

    // s0 + round((s1 - s0) * frac), ties upward
    assign w_diff = {r_s1_4[SB-1], r_s1_4} - {r_s0_4[SB-1], r_s0_4};
    assign w_rnd  = r_prod5 + ROUND_HALF;
    assign w_res  = {{2{r_s0_5[SB-1]}}, r_s0_5} + w_rnd[PROD_W-1:FRAC_BITS];
    assign n_out  = r_ok5 ? w_res[SB-1:0] : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v4 <= 1'b0;
            r_v5 <= 1'b0;
            r_v6 <= 1'b0;
        end else begin
            if (w_en4) begin
                r_v4 <= w_pos_valid && (w_pos_item.is_req == REQ_READ);
            end
            if (w_en5) begin
                r_v5 <= r_v4;
            end
            if (w_en6) begin
                r_v6 <= r_v5;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en4) begin
            r_ok4   <= w_pos_item.in_range;
            r_frac4 <= w_pos_item.frac;
            r_didx4 <= w_pos_item.dest_index;
        end
        if (w_en5) begin
            r_prod5 <= w_diff * $signed({1'b0, r_frac4});
            r_s0_5  <= r_s0_4;
            r_ok5   <= r_ok4;
            r_didx5 <= r_didx4;
        end
        if (w_en6) begin
            r_out6  <= n_out;
            r_ok6   <= r_ok5;
            r_didx6 <= r_didx5;
        end
    end

    assign o_valid      = r_v6;
    assign o_out_sample = r_out6;
    assign o_out_index  = r_didx6;
    assign o_in_range   = r_ok6;

    a_zero_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_in_range) |-> (o_out_sample == '0))
        else $error("out-of-range result is not zero");

    a_stall_only_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> (r_v4 && r_v5 && r_v6 && i_stall))
        else $error("input stalled while the back end has room");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result valid straight after reset");

endmodule
